// ===== rtl/shsort_pkg.sv =====
// Shared types, constants and tables for the shellsort batch sorter.
// Holds the Sedgewick gap table, the microcode ROM and control structs.
// No dependencies.
package shsort_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int VALUE_WIDTH_DEF  = 32;

  // configuration register
  localparam int                COUNT_W           = 11;
  localparam logic [COUNT_W-1:0] COUNT_RESET      = 11'd1024;
  localparam int                PADDR_W           = 3;
  localparam logic              REG_ELEMENT_COUNT = 1'b0;

  // input actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  // gap table
  localparam int GAP_W     = 18;
  localparam int GAP_IDX_W = 4;

  function automatic logic [GAP_W-1:0] gap_of(input logic [GAP_IDX_W-1:0] k);
    logic [GAP_W-1:0] g;
    unique case (k)
      4'd0:  g = 18'd1;
      4'd1:  g = 18'd5;
      4'd2:  g = 18'd19;
      4'd3:  g = 18'd41;
      4'd4:  g = 18'd109;
      4'd5:  g = 18'd209;
      4'd6:  g = 18'd505;
      4'd7:  g = 18'd929;
      4'd8:  g = 18'd2161;
      4'd9:  g = 18'd3905;
      4'd10: g = 18'd8929;
      4'd11: g = 18'd16001;
      4'd12: g = 18'd36289;
      4'd13: g = 18'd64769;
      4'd14: g = 18'd146305;
      4'd15: g = 18'd260609;
    endcase
    return g;
  endfunction

  // microcode
  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_FIND  = 3'd0;
  localparam step_t STEP_GAP   = 3'd1;
  localparam step_t STEP_ITEST = 3'd2;
  localparam step_t STEP_HOLD  = 3'd3;
  localparam step_t STEP_CMP   = 3'd4;
  localparam step_t STEP_PLACE = 3'd5;
  localparam step_t STEP_KDEC  = 3'd6;
  localparam step_t STEP_DONE  = 3'd7;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_GAP_FITS,
    COND_I_DONE,
    COND_SHIFT_MORE,
    COND_K_NONZERO
  } cond_t;

  typedef enum logic [1:0] {
    GUARD_ALL,
    GUARD_COND,
    GUARD_GREATER
  } guard_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_I,
    RD_J_G,
    RD_J_2G
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_HOLD
  } wr_sel_t;

  typedef struct packed {
    cond_t   cond;
    step_t   target;
    guard_t  guard;
    logic    k_inc;
    logic    k_dec;
    logic    g_load;
    logic    i_load;
    logic    i_inc;
    logic    j_load;
    logic    j_sub;
    logic    hold_load;
    rd_sel_t rd;
    wr_sel_t wr;
    logic    done;
  } ucode_t;

  typedef struct packed {
    logic    k_inc;
    logic    k_dec;
    logic    g_load;
    logic    i_load;
    logic    i_inc;
    logic    j_load;
    logic    j_sub;
    logic    hold_load;
    rd_sel_t rd;
    wr_sel_t wr;
  } dp_ctrl_t;

  typedef struct packed {
    logic gap_fits;
    logic i_done;
    logic shift_more;
    logic greater;
    logic k_nonzero;
  } sort_stat_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    w        = '0;
    w.cond   = COND_ALWAYS;
    w.target = STEP_FIND;
    w.guard  = GUARD_ALL;
    w.rd     = RD_NONE;
    w.wr     = WR_NONE;
    unique case (step)
      STEP_FIND: begin
        // climb to the largest gap that fits the batch
        w.cond   = COND_GAP_FITS;
        w.target = STEP_FIND;
        w.guard  = GUARD_COND;
        w.k_inc  = 1'b1;
      end
      STEP_GAP: begin
        w.g_load = 1'b1;
        w.i_load = 1'b1;
        w.target = STEP_ITEST;
      end
      STEP_ITEST: begin
        w.cond   = COND_I_DONE;
        w.target = STEP_KDEC;
        w.rd     = RD_I;
        w.j_load = 1'b1;
      end
      STEP_HOLD: begin
        w.hold_load = 1'b1;
        w.rd        = RD_J_G;
        w.target    = STEP_CMP;
      end
      STEP_CMP: begin
        // shift the larger neighbour up and fetch the next one down
        w.cond   = COND_SHIFT_MORE;
        w.target = STEP_CMP;
        w.guard  = GUARD_GREATER;
        w.wr     = WR_SHIFT;
        w.j_sub  = 1'b1;
        w.rd     = RD_J_2G;
      end
      STEP_PLACE: begin
        w.wr     = WR_HOLD;
        w.i_inc  = 1'b1;
        w.target = STEP_ITEST;
      end
      STEP_KDEC: begin
        w.cond   = COND_K_NONZERO;
        w.target = STEP_GAP;
        w.guard  = GUARD_COND;
        w.k_dec  = 1'b1;
      end
      STEP_DONE: begin
        w.target = STEP_FIND;
        w.done   = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/shsort_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
module shsort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/shsort_useq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on shsort_pkg.
module shsort_useq
  import shsort_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       run,
  input  sort_stat_t stat,
  output dp_ctrl_t   ctrl,
  output logic       done
);

  step_t  step_r;
  step_t  step_nxt;
  ucode_t word;
  logic   cond_true;
  logic   gate;
  logic   act;

  assign word = ucode_rom(step_r);

  always_comb begin
    unique case (word.cond)
      COND_ALWAYS:     cond_true = 1'b1;
      COND_GAP_FITS:   cond_true = stat.gap_fits;
      COND_I_DONE:     cond_true = stat.i_done;
      COND_SHIFT_MORE: cond_true = stat.shift_more;
      COND_K_NONZERO:  cond_true = stat.k_nonzero;
      default:         cond_true = 1'b0;
    endcase
  end

  always_comb begin
    unique case (word.guard)
      GUARD_ALL:     gate = 1'b1;
      GUARD_COND:    gate = cond_true;
      GUARD_GREATER: gate = stat.greater;
      default:       gate = 1'b0;
    endcase
  end

  assign act = run & gate;

  always_comb begin
    ctrl.k_inc     = act & word.k_inc;
    ctrl.k_dec     = act & word.k_dec;
    ctrl.g_load    = act & word.g_load;
    ctrl.i_load    = act & word.i_load;
    ctrl.i_inc     = act & word.i_inc;
    ctrl.j_load    = act & word.j_load;
    ctrl.j_sub     = act & word.j_sub;
    ctrl.hold_load = act & word.hold_load;
    ctrl.rd        = act ? word.rd : RD_NONE;
    ctrl.wr        = act ? word.wr : WR_NONE;
    done           = run & word.done;
  end

  always_comb begin
    if (!run) begin
      step_nxt = STEP_FIND;
    end else if (cond_true) begin
      step_nxt = word.target;
    end else begin
      step_nxt = step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_FIND;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== rtl/shsort_dpath.sv =====
// Sort datapath: gap index, gap, outer and inner indexes, held value,
// compare and address selection.  Depends on shsort_pkg.
module shsort_dpath
  import shsort_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dp_ctrl_t                        ctrl,
  input  logic [$clog2(MAX_ELEMENTS):0]   n,
  input  logic [VALUE_WIDTH-1:0]          rd_data,
  output sort_stat_t                      stat,
  output logic                            rd_en,
  output logic [$clog2(MAX_ELEMENTS)-1:0] rd_addr,
  output logic                            wr_en,
  output logic [$clog2(MAX_ELEMENTS)-1:0] wr_addr,
  output logic [VALUE_WIDTH-1:0]          wr_data
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = AW + 1;

  logic [GAP_IDX_W-1:0]   k_r;
  logic [CW-1:0]          g_r;
  logic [CW-1:0]          i_r;
  logic [CW-1:0]          j_r;
  logic [VALUE_WIDTH-1:0] hold_r;

  logic [GAP_IDX_W-1:0] k_up;
  logic [CW-1:0]        gap_now;
  logic [CW-1:0]        jm;
  logic [CW-1:0]        jm2;

  assign k_up    = k_r + GAP_IDX_W'(1);
  assign gap_now = CW'(gap_of(k_r));
  assign jm      = j_r - g_r;
  assign jm2     = jm - g_r;

  always_comb begin
    stat.greater    = $signed(rd_data) > $signed(hold_r);
    stat.gap_fits   = (k_r != '1) && (gap_of(k_up) <= GAP_W'(n));
    stat.i_done     = i_r >= n;
    stat.shift_more = stat.greater && (jm >= g_r);
    stat.k_nonzero  = k_r != '0;
  end

  always_comb begin
    rd_en = ctrl.rd != RD_NONE;
    case (ctrl.rd)
      RD_I:    rd_addr = i_r[AW-1:0];
      RD_J_G:  rd_addr = jm[AW-1:0];
      RD_J_2G: rd_addr = jm2[AW-1:0];
      default: rd_addr = i_r[AW-1:0];
    endcase
    wr_en   = ctrl.wr != WR_NONE;
    wr_addr = j_r[AW-1:0];
    wr_data = (ctrl.wr == WR_HOLD) ? hold_r : rd_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (ctrl.k_inc) begin
      k_r <= k_up;
    end else if (ctrl.k_dec) begin
      k_r <= k_r - GAP_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.g_load) begin
      g_r <= gap_now;
    end
    if (ctrl.i_load) begin
      i_r <= gap_now;
    end else if (ctrl.i_inc) begin
      i_r <= i_r + CW'(1);
    end
    if (ctrl.j_load) begin
      j_r <= i_r;
    end else if (ctrl.j_sub) begin
      j_r <= jm;
    end
    if (ctrl.hold_load) begin
      hold_r <= rd_data;
    end
  end

endmodule

// ===== rtl/shell_sort_sedgewick_gaps_top.sv =====
// Batch shellsort with Sedgewick gaps: top level with handshakes, config
// register, load and fetch control.  Depends on shsort_pkg and submodules.
//
// Loads (action 0) write values into a store until element_count values are
// held; the load that completes the batch starts the sort and input stalls
// until it ends.  Fetches (action 1) then return the values in ascending
// order, one result each, with last set on the final one, and the block goes
// back to loading.  Input stalls while a result waits at the output.  The sort
// is run by a microcoded sequencer against the single-read, single-write
// store: it climbs the gap table to the largest gap that fits the batch,
// then for each gap inserts every element from the gap upward, holding it,
// shifting larger neighbours one gap up and placing it, and steps down to
// the next smaller gap until gap one is done.  The store is not cleared
// after reset; it needs no start-up pass.
module shell_sort_sedgewick_gaps_top
  import shsort_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] out_sorted_value,
  output logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = AW + 1;

  logic [COUNT_W-1:0] count_r;
  logic               sorting_r;
  logic               sorted_r;
  logic [CW-1:0]      loaded_r;
  logic [AW-1:0]      rpos_r;
  logic               out_valid_r;
  logic               out_last_r;

  logic               sorting_nxt;
  logic               sorted_nxt;
  logic [CW-1:0]      loaded_nxt;
  logic [AW-1:0]      rpos_nxt;
  logic               out_valid_nxt;
  logic               out_last_nxt;

  logic [CW-1:0]      n;
  logic               in_xfer;
  logic               load_go;
  logic               fetch_go;
  logic               room;
  logic [CW-1:0]      cnt_after;
  logic [CW-1:0]      rpos_up;
  logic               fin;
  logic               cfg_wr;

  dp_ctrl_t           ctrl;
  sort_stat_t         stat;
  logic               sort_done;

  logic                   dp_rd_en;
  logic [AW-1:0]          dp_rd_addr;
  logic                   dp_wr_en;
  logic [AW-1:0]          dp_wr_addr;
  logic [VALUE_WIDTH-1:0] dp_wr_data;

  logic                   ram_wr_en;
  logic [AW-1:0]          ram_wr_addr;
  logic [VALUE_WIDTH-1:0] ram_wr_data;
  logic                   ram_rd_en;
  logic [AW-1:0]          ram_rd_addr;
  logic [VALUE_WIDTH-1:0] ram_rd_data;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[PADDR_W-1] == REG_ELEMENT_COUNT) ? 32'(count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
    end else if (cfg_wr && (paddr[PADDR_W-1] == REG_ELEMENT_COUNT)) begin
      count_r <= pwdata[COUNT_W-1:0];
    end
  end

  // effective batch size: zero acts as one, clamp to the store depth
  always_comb begin
    if (count_r == '0) begin
      n = CW'(1);
    end else if (32'(count_r) > MAX_ELEMENTS) begin
      n = CW'(MAX_ELEMENTS);
    end else begin
      n = CW'(count_r);
    end
  end

  assign in_ready = !sorting_r && (!out_valid_r || out_ready);
  assign in_xfer  = in_valid & in_ready;
  assign load_go  = in_xfer && (in_action == ACT_LOAD) && !sorted_r;
  assign fetch_go = in_xfer && (in_action == ACT_FETCH) && sorted_r;

  assign room      = loaded_r < n;
  assign cnt_after = loaded_r + {{(CW-1){1'b0}}, room};
  assign rpos_up   = {1'b0, rpos_r} + CW'(1);
  assign fin       = (rpos_up >= n) || (rpos_up >= CW'(MAX_ELEMENTS));

  always_comb begin
    sorting_nxt   = sorting_r;
    sorted_nxt    = sorted_r;
    loaded_nxt    = loaded_r;
    rpos_nxt      = rpos_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (sort_done) begin
      sorting_nxt = 1'b0;
    end
    if (load_go) begin
      loaded_nxt = cnt_after;
      if (cnt_after >= n) begin
        sorting_nxt = 1'b1;
        sorted_nxt  = 1'b1;
        rpos_nxt    = '0;
      end
    end
    if (fetch_go) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = fin;
      if (fin) begin
        sorted_nxt = 1'b0;
        loaded_nxt = '0;
        rpos_nxt   = '0;
      end else begin
        rpos_nxt = rpos_up[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sorting_r   <= 1'b0;
      sorted_r    <= 1'b0;
      loaded_r    <= '0;
      rpos_r      <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      sorting_r   <= sorting_nxt;
      sorted_r    <= sorted_nxt;
      loaded_r    <= loaded_nxt;
      rpos_r      <= rpos_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  // the sorter owns the store while it runs
  always_comb begin
    if (sorting_r) begin
      ram_wr_en   = dp_wr_en;
      ram_wr_addr = dp_wr_addr;
      ram_wr_data = dp_wr_data;
      ram_rd_en   = dp_rd_en;
      ram_rd_addr = dp_rd_addr;
    end else begin
      ram_wr_en   = load_go && room;
      ram_wr_addr = loaded_r[AW-1:0];
      ram_wr_data = in_value;
      ram_rd_en   = fetch_go;
      ram_rd_addr = rpos_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_last         = out_last_r;
  assign out_sorted_value = ram_rd_data;

  shsort_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .run   (sorting_r),
    .stat  (stat),
    .ctrl  (ctrl),
    .done  (sort_done)
  );

  shsort_dpath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .n       (n),
    .rd_data (ram_rd_data),
    .stat    (stat),
    .rd_en   (dp_rd_en),
    .rd_addr (dp_rd_addr),
    .wr_en   (dp_wr_en),
    .wr_addr (dp_wr_addr),
    .wr_data (dp_wr_data)
  );

  shsort_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  a_sort_in_fetch_phase: assert property (@(posedge clk) disable iff (!rst_n)
    sorting_r |-> sorted_r)
    else $error("sort running outside the sorted phase");

  a_fetch_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fetch_go |=> out_valid_r)
    else $error("fetch transfer produced no result");

  a_sort_ends_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(sorting_r) |-> $past(sort_done))
    else $error("sort ended without reaching the final step");

  a_rpos_only_when_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (rpos_r != '0) |-> sorted_r)
    else $error("read position moved outside the fetch phase");

endmodule
